// ===== rtl/core/periodic_timer_bank_macros.svh =====
// Assertion macros used by the checker file of the timer bank.
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTB_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ptb_pkg.sv =====
package ptb_pkg;

  localparam int unsigned NUM_TIMERS = 16;
  localparam int unsigned SLOT_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_TIMERS + 1);

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_KILL   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_FIRE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_KILL = 2'd2
  } kind_e;

  typedef struct packed {
    logic [23:0] interval;
    logic [31:0] remaining;
    logic [15:0] tag;
  } slot_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    slot_t             wdata;
    logic              set_valid;
    logic              clr_valid;
    logic [SLOT_W-1:0] vaddr;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } store_req_t;

endpackage

// ===== rtl/core/ptb_store.sv =====
module ptb_store (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ptb_pkg::store_req_t                 req_i,
  output logic [ptb_pkg::NUM_TIMERS-1:0]      valid_o,
  output ptb_pkg::slot_t                      rd_data_o
);
  import ptb_pkg::*;

  slot_t                 mem [NUM_TIMERS];
  slot_t                 rd_data_q;
  logic [NUM_TIMERS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.set_valid) begin
      valid_q[req_i.vaddr] <= 1'b1;
    end else if (req_i.clr_valid) begin
      valid_q[req_i.vaddr] <= 1'b0;
    end
  end

  assign valid_o   = valid_q;
  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/core/periodic_timer_bank.sv =====
// Bank of periodic timers held in a one-port-read, one-port-write slot memory.
// Input channel (in_valid_i/in_ready_o) takes one command beat: tick, create,
// kill or none. Output channel (out_valid_o/out_ready_i) returns result beats.
// A create is written in the cycle it is accepted and returns nothing; the
// next command can be accepted in the following cycle.
// A kill returns one beat, marked last, set in the kill state and held in the
// output register, telling whether a live timer was removed.
// A tick streams the slots through the memory read port, one slot per cycle
// while the output does not stall: each live slot whose count reaches zero or
// below gives a fire beat, and a closing beat marked last follows once the
// last slot has been read and written back.
// Commands are accepted only while no command is in progress.
// The output register holds a beat until it is taken; while the receiver
// stalls, a tick waits on the slot that must report and resumes afterwards.
// Reset clears all valid marks; interval, count and tag memory contents are
// undefined until a create writes them.
module periodic_timer_bank (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  timer_index_i,
  input  logic [23:0] interval_i,
  input  logic [15:0] handler_tag_i,
  input  logic [15:0] elapsed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [3:0]  slot_o,
  output logic [15:0] tag_o,
  output logic        removed_o,
  output logic        last_o
);
  import ptb_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TICK = 3'b010,
    S_KILL = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic              p_vld_q, p_vld_d;
  logic [SLOT_W-1:0] p_idx_q, p_idx_d;
  logic [15:0]       elapsed_q, elapsed_d;
  logic [3:0]        kill_slot_q, kill_slot_d;
  logic              kill_rm_q, kill_rm_d;

  logic              out_vld_q, out_vld_d;
  logic [1:0]        kind_q, kind_d;
  logic [3:0]        slot_q, slot_d;
  logic [15:0]       tag_q, tag_d;
  logic              removed_q, removed_d;
  logic              last_q, last_d;

  store_req_t            req;
  logic [NUM_TIMERS-1:0] valid;
  slot_t                 rd_data;

  logic              accept;
  logic              out_free;
  logic              idx_ok;
  logic [SLOT_W-1:0] in_slot;
  logic              slot_vld;
  logic [32:0]       diff;
  logic [31:0]       sat;
  logic              fire;
  logic [31:0]       new_rem;
  logic              need_out;
  logic              stall;

  ptb_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .valid_o   (valid),
    .rd_data_o (rd_data)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_vld_q || out_ready_i;
  assign idx_ok     = (9'(timer_index_i) < 9'(NUM_TIMERS));
  assign in_slot    = SLOT_W'(timer_index_i);

  assign slot_vld = valid[p_idx_q];
  assign diff     = {rd_data.remaining[31], rd_data.remaining} - {17'd0, elapsed_q};
  assign sat      = (diff[32] != diff[31]) ? 32'h8000_0000 : diff[31:0];
  assign fire     = sat[31] || (sat == 32'd0);
  assign new_rem  = fire ? (sat + {8'd0, rd_data.interval}) : sat;
  assign need_out = p_vld_q && slot_vld && fire;
  assign stall    = need_out && !out_free;

  always_comb begin
    state_d     = state_q;
    rd_ptr_d    = rd_ptr_q;
    p_vld_d     = p_vld_q;
    p_idx_d     = p_idx_q;
    elapsed_d   = elapsed_q;
    kill_slot_d = kill_slot_q;
    kill_rm_d   = kill_rm_q;
    out_vld_d   = out_vld_q && !out_ready_i;
    kind_d      = kind_q;
    slot_d      = slot_q;
    tag_d       = tag_q;
    removed_d   = removed_q;
    last_d      = last_q;
    req         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_TICK: begin
              elapsed_d = elapsed_i;
              rd_ptr_d  = '0;
              p_vld_d   = 1'b0;
              state_d   = S_TICK;
            end
            CMD_CREATE: begin
              if (idx_ok) begin
                req.we              = 1'b1;
                req.waddr           = in_slot;
                req.wdata.interval  = interval_i;
                req.wdata.remaining = {8'd0, interval_i};
                req.wdata.tag       = handler_tag_i;
                req.set_valid       = 1'b1;
                req.vaddr           = in_slot;
              end
            end
            CMD_KILL: begin
              kill_slot_d = timer_index_i;
              kill_rm_d   = idx_ok && valid[in_slot];
              req.clr_valid = idx_ok;
              req.vaddr     = in_slot;
              state_d       = S_KILL;
            end
            default: begin
            end
          endcase
        end
      end
      S_TICK: begin
        if (!stall) begin
          if (p_vld_q && slot_vld) begin
            req.we              = 1'b1;
            req.waddr           = p_idx_q;
            req.wdata.interval  = rd_data.interval;
            req.wdata.remaining = new_rem;
            req.wdata.tag       = rd_data.tag;
          end
          if (need_out) begin
            out_vld_d = 1'b1;
            kind_d    = KIND_FIRE;
            slot_d    = 4'(p_idx_q);
            tag_d     = rd_data.tag;
            removed_d = 1'b0;
            last_d    = 1'b0;
          end
          if (rd_ptr_q != CNT_W'(NUM_TIMERS)) begin
            req.re   = 1'b1;
            req.raddr = rd_ptr_q[SLOT_W-1:0];
            p_vld_d  = 1'b1;
            p_idx_d  = rd_ptr_q[SLOT_W-1:0];
            rd_ptr_d = rd_ptr_q + CNT_W'(1);
          end else begin
            p_vld_d = 1'b0;
            if (!p_vld_q && out_free) begin
              out_vld_d = 1'b1;
              kind_d    = KIND_DONE;
              slot_d    = 4'd0;
              tag_d     = 16'd0;
              removed_d = 1'b0;
              last_d    = 1'b1;
              state_d   = S_IDLE;
            end
          end
        end
      end
      S_KILL: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          kind_d    = KIND_KILL;
          slot_d    = kill_slot_q;
          tag_d     = 16'd0;
          removed_d = kill_rm_q;
          last_d    = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_ptr_q  <= '0;
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_ptr_q  <= rd_ptr_d;
      p_vld_q   <= p_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q     <= p_idx_d;
    elapsed_q   <= elapsed_d;
    kill_slot_q <= kill_slot_d;
    kill_rm_q   <= kill_rm_d;
    kind_q      <= kind_d;
    slot_q      <= slot_d;
    tag_q       <= tag_d;
    removed_q   <= removed_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_vld_q;
  assign kind_o      = kind_q;
  assign slot_o      = slot_q;
  assign tag_o       = tag_q;
  assign removed_o   = removed_q;
  assign last_o      = last_q;

endmodule

// ===== rtl/core/ptb_checker.sv =====
`include "periodic_timer_bank_macros.svh"

module ptb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [3:0]  slot_o,
  input logic [15:0] tag_o,
  input logic        removed_o,
  input logic        last_o
);
  import ptb_pkg::*;

  // A result beat stays offered until it is taken.
  `PTB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // A stalled result beat keeps its payload.
  `PTB_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
    $stable(kind_o) && $stable(slot_o) && $stable(tag_o) && $stable(removed_o) && $stable(last_o))

  // A tick or kill keeps the input closed until its last beat is produced.
  `PTB_ASSERT_NEXT(a_busy_after_cmd, clk_i, rst_ni,
    in_valid_i && in_ready_o && (cmd_i == CMD_TICK || cmd_i == CMD_KILL), !in_ready_o)

  // Fire beats are never last and never claim a removal.
  `PTB_ASSERT_IMPL(a_fire_fields, clk_i, rst_ni, out_valid_o && kind_o == KIND_FIRE,
    !last_o && !removed_o)

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .kind_o      (kind_o),
  .slot_o      (slot_o),
  .tag_o       (tag_o),
  .removed_o   (removed_o),
  .last_o      (last_o)
);

// ===== tb/periodic_timer_bank_test.sv =====
module periodic_timer_bank_test;
  import ptb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 410;
  localparam int SOAK_TICKS = 8;
  localparam int DRAIN_CYCLES = 2 * NUM_TIMERS + 8;
  localparam int MAX_REPORTS = 10;
  localparam longint COUNT_FLOOR = -64'sd2147483648;
  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [23:0] INTERVAL_MAX = 24'hFF_FFFF;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot;
    logic [15:0] tag;
    logic        removed;
    logic        last;
  } timer_beat_t;

  typedef struct {
    cmd_e        cmd;
    logic [3:0]  idx;
    logic [23:0] interval;
    logic [15:0] tag;
    logic [15:0] elapsed;
    bit          typed;
    timer_beat_t answer;
  } command_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = CMD_TICK;
  logic [3:0]  timer_index_i = 4'd0;
  logic [23:0] interval_i = 24'd0;
  logic [15:0] handler_tag_i = 16'd0;
  logic [15:0] elapsed_i = 16'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [3:0]  slot_o;
  logic [15:0] tag_o;
  logic        removed_o;
  logic        last_o;

  bit          bank_live [NUM_TIMERS];
  logic [23:0] bank_period [NUM_TIMERS];
  int          bank_count [NUM_TIMERS];
  logic [15:0] bank_tag [NUM_TIMERS];
  timer_beat_t due_beats [$];
  command_t    script [$];

  int item_count = 0;
  int tick_count = 0;
  int fire_count = 0;
  int create_count = 0;
  int kill_count = 0;
  int removed_count = 0;
  int floor_count = 0;
  int beat_count = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int burst_left = 0;
  bit soak_mode = 1'b0;
  bit rx_level = 1'b0;
  int rx_run = 0;

  periodic_timer_bank uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .timer_index_i (timer_index_i),
    .interval_i    (interval_i),
    .handler_tag_i (handler_tag_i),
    .elapsed_i     (elapsed_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .slot_o        (slot_o),
    .tag_o         (tag_o),
    .removed_o     (removed_o),
    .last_o        (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  task automatic predict_command(input command_t c);
    timer_beat_t beats [$];
    timer_beat_t beat;
    longint      level;
    bit          was_live;
    case (c.cmd)
      CMD_TICK: begin
        tick_count++;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (bank_live[i]) begin
            level = longint'(bank_count[i]) - longint'(c.elapsed);
            if (level < COUNT_FLOOR) begin
              level = COUNT_FLOOR;
              floor_count++;
            end
            if (level <= 0) begin
              beat = '{KIND_FIRE, 4'(i), bank_tag[i], 1'b0, 1'b0};
              beats.push_back(beat);
              level += longint'(bank_period[i]);
              fire_count++;
            end
            bank_count[i] = int'(level);
          end
        end
        beat = '{KIND_DONE, 4'd0, 16'd0, 1'b0, 1'b1};
        beats.push_back(beat);
      end
      CMD_CREATE: begin
        create_count++;
        if (int'(c.idx) < NUM_TIMERS) begin
          bank_live[c.idx] = 1'b1;
          bank_period[c.idx] = c.interval;
          bank_count[c.idx] = int'({8'd0, c.interval});
          bank_tag[c.idx] = c.tag;
        end
      end
      CMD_KILL: begin
        kill_count++;
        was_live = (int'(c.idx) < NUM_TIMERS) && bank_live[c.idx];
        if (was_live) begin
          bank_live[c.idx] = 1'b0;
          removed_count++;
        end
        beat = '{KIND_KILL, c.idx, 16'd0, was_live, 1'b1};
        beats.push_back(beat);
      end
      default: begin
      end
    endcase
    if (c.typed) begin
      due_beats.push_back(c.answer);
    end else begin
      foreach (beats[k]) due_beats.push_back(beats[k]);
    end
  endtask

  task automatic send_command(input command_t c);
    cmd_i <= c.cmd;
    timer_index_i <= c.idx;
    interval_i <= c.interval;
    handler_tag_i <= c.tag;
    elapsed_i <= c.elapsed;
    in_valid_i <= 1'b1;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    predict_command(c);
    @(posedge clk_i);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(10, 1);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(16, 1);
    end
  endtask

  task automatic add_row(input cmd_e cmd, input logic [3:0] idx, input logic [23:0] ivl,
                         input logic [15:0] tg, input logic [15:0] elp, input bit typed,
                         input kind_e kind, input logic removed);
    command_t c;
    c.cmd = cmd;
    c.idx = idx;
    c.interval = ivl;
    c.tag = tg;
    c.elapsed = elp;
    c.typed = typed;
    c.answer = '{kind, (kind == KIND_KILL) ? idx : 4'd0, 16'd0, removed, 1'b1};
    script.push_back(c);
  endtask

  task automatic draw_command(output command_t c);
    int pick;
    pick = $urandom_range(99, 0);
    c.cmd = (pick < 35) ? CMD_TICK : (pick < 75) ? CMD_CREATE : (pick < 95) ? CMD_KILL : CMD_NONE;
    c.idx = 4'($urandom_range(15, 0));
    pick = $urandom_range(99, 0);
    c.interval = (pick < 60) ? 24'($urandom_range(24, 0)) :
                 (pick < 85) ? 24'($urandom_range(4096, 0)) : 24'($urandom);
    c.tag = 16'($urandom);
    pick = $urandom_range(99, 0);
    c.elapsed = (pick < 50) ? 16'($urandom_range(8, 0)) :
                (pick < 80) ? 16'($urandom_range(64, 0)) : 16'($urandom);
    c.typed = 1'b0;
    c.answer = '{KIND_DONE, 4'd0, 16'd0, 1'b0, 1'b1};
  endtask

  always @(posedge clk_i) begin
    if (soak_mode) begin
      rx_level = 1'b1;
    end else if (rx_run == 0) begin
      if ($urandom_range(9, 0) == 0) begin
        rx_level = 1'b1;
        rx_run = $urandom_range(80, 30);
      end else begin
        rx_level = ~rx_level;
        rx_run = rx_level ? $urandom_range(6, 1) : $urandom_range(5, 1);
      end
    end else begin
      rx_run--;
    end
    out_ready_i <= rx_level;
  end

  always @(negedge clk_i) begin
    timer_beat_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_valid_o && out_ready_i) begin
        beat_count++;
        if (due_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("beat with nothing expected: kind %0d slot %0d tag %h removed %b last %b",
                     kind_o, slot_o, tag_o, removed_o, last_o);
          end
        end else begin
          want = due_beats.pop_front();
          if (kind_o !== want.kind || slot_o !== want.slot || tag_o !== want.tag ||
              removed_o !== want.removed || last_o !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("beat %0d: expected kind %0d slot %0d tag %h removed %b last %b",
                       beat_count, want.kind, want.slot, want.tag, want.removed, want.last);
              $display("beat %0d:      got kind %0d slot %0d tag %h removed %b last %b",
                       beat_count, kind_o, slot_o, tag_o, removed_o, last_o);
            end
          end
        end
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no beat moved for %0d cycles with %0d results outstanding",
                 quiet_cycles, due_beats.size());
        $display("periodic_timer_bank_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    command_t c;
    add_row(CMD_TICK,   4'd0,  24'd0,        16'h0000, 16'd0,       1, KIND_DONE, 1'b0);
    add_row(CMD_KILL,   4'd0,  24'd0,        16'h0000, 16'd0,       1, KIND_KILL, 1'b0);
    add_row(CMD_KILL,   4'd15, 24'd0,        16'h0000, 16'd0,       1, KIND_KILL, 1'b0);
    add_row(CMD_NONE,   4'd15, INTERVAL_MAX, 16'hFFFF, ELAPSED_MAX, 0, KIND_DONE, 1'b0);
    add_row(CMD_CREATE, 4'd0,  24'd0,        16'hFFFF, 16'd0,       0, KIND_DONE, 1'b0);
    add_row(CMD_TICK,   4'd0,  24'd0,        16'h0000, 16'd0,       0, KIND_DONE, 1'b0);
    add_row(CMD_CREATE, 4'd15, INTERVAL_MAX, 16'h0000, 16'd0,       0, KIND_DONE, 1'b0);
    add_row(CMD_CREATE, 4'd7,  24'd5,        16'h1234, 16'd0,       0, KIND_DONE, 1'b0);
    add_row(CMD_TICK,   4'd0,  24'd0,        16'h0000, ELAPSED_MAX, 0, KIND_DONE, 1'b0);
    add_row(CMD_TICK,   4'd0,  24'd0,        16'h0000, 16'd3,       0, KIND_DONE, 1'b0);
    add_row(CMD_CREATE, 4'd7,  24'd1,        16'hABCD, 16'd0,       0, KIND_DONE, 1'b0);
    add_row(CMD_TICK,   4'd0,  24'd0,        16'h0000, 16'd1,       0, KIND_DONE, 1'b0);
    add_row(CMD_CREATE, 4'd3,  24'd2,        16'h5A5A, 16'd0,       0, KIND_DONE, 1'b0);
    add_row(CMD_CREATE, 4'd12, 24'd0,        16'hA5A5, 16'd0,       0, KIND_DONE, 1'b0);
    add_row(CMD_TICK,   4'd0,  24'd0,        16'h0000, 16'd2,       0, KIND_DONE, 1'b0);
    add_row(CMD_KILL,   4'd7,  24'd0,        16'h0000, 16'd0,       1, KIND_KILL, 1'b1);
    add_row(CMD_KILL,   4'd7,  24'd0,        16'h0000, 16'd0,       1, KIND_KILL, 1'b0);
    add_row(CMD_KILL,   4'd15, 24'd0,        16'h0000, 16'd0,       1, KIND_KILL, 1'b1);
    add_row(CMD_TICK,   4'd0,  24'd0,        16'h0000, ELAPSED_MAX, 0, KIND_DONE, 1'b0);
    add_row(CMD_CREATE, 4'd15, 24'd0,        16'h0FF0, 16'd0,       0, KIND_DONE, 1'b0);
    add_row(CMD_TICK,   4'd0,  24'd0,        16'h0000, 16'd0,       0, KIND_DONE, 1'b0);
    add_row(CMD_NONE,   4'd0,  24'd0,        16'h0000, 16'd0,       0, KIND_DONE, 1'b0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r]) begin
      send_command(script[r]);
      pace_sender();
    end

    while (item_count < RANDOM_ITEMS) begin
      draw_command(c);
      if (c.cmd != CMD_NONE) item_count++;
      send_command(c);
      pace_sender();
    end

    // Load every slot so that each tick reports all but slot 2, whose interval is
    // the largest, then run SOAK_TICKS ticks back to back with the largest step.
    for (int i = 0; i < NUM_TIMERS; i++) begin
      c.cmd = CMD_CREATE;
      c.idx = 4'(i);
      c.interval = (i == 1) ? 24'd1 : (i == 2) ? INTERVAL_MAX : 24'd0;
      c.tag = 16'($urandom);
      c.elapsed = 16'd0;
      c.typed = 1'b0;
      send_command(c);
      pace_sender();
    end
    soak_mode = 1'b1;
    c.cmd = CMD_TICK;
    c.elapsed = ELAPSED_MAX;
    repeat (SOAK_TICKS) send_command(c);
    in_valid_i <= 1'b0;

    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d ticks with %0d fires, %0d creates and %0d kills (%0d removed a timer)",
             tick_count, fire_count, create_count, kill_count, removed_count);
    $display("counts pinned at the negative limit %0d times; %0d beats checked, %0d mismatches",
             floor_count, beat_count, mismatches);
    if (mismatches == 0) begin
      $display("periodic_timer_bank_test: PASS");
    end else begin
      $display("periodic_timer_bank_test: FAIL");
    end
    $finish;
  end

endmodule
